/* sv/dbfw_pkg.sv */
// ----------------------------------------------------------------------------
// dbfw_pkg
// Shared types and constants for the sector write-back buffer controller.
// ----------------------------------------------------------------------------
package dbfw_pkg;

    localparam int ADDR_W    = 25;
    localparam int TOTAL_W   = 17;
    localparam int BOFF_W    = 12;
    localparam int CNT_W     = 10;
    localparam int BN_W      = 16;
    localparam int LEN_W     = 10;
    localparam int MAX_MERGE = 7;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_SYNC  = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        K_NONE      = 4'd0,
        K_WRITE     = 4'd1,
        K_READ_BUF  = 4'd2,
        K_READ_FL   = 4'd3,
        K_MERGE     = 4'd4,
        K_ERASE     = 4'd5,
        K_PROGRAM   = 4'd6,
        K_DONE      = 4'd7,
        K_RANGE_ERR = 4'd8,
        K_RETRY     = 4'd9,
        K_SYNC_BUSY = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        BP_FREE     = 2'd0,
        BP_ACTIVE   = 2'd1,
        BP_PENDING  = 2'd2,
        BP_FLUSHING = 2'd3
    } bphase_t;

    typedef enum logic [2:0] {
        FL_IDLE        = 3'd0,
        FL_ERASE_START = 3'd1,
        FL_ERASE_WAIT  = 3'd2,
        FL_PAGE_START  = 3'd3,
        FL_DMA_WAIT    = 3'd4,
        FL_BUSY_WAIT   = 3'd5
    } fphase_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic                sel;
        logic [BOFF_W-1:0]   boff;
        logic [CNT_W-1:0]    cnt;
    } res_t;

endpackage

/* sv/dbfw_queue.sv */
// ----------------------------------------------------------------------------
// dbfw_queue
// Two-entry FIFO between the classifying front end and the result back end.
// ----------------------------------------------------------------------------
module dbfw_queue #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         q_valid,
    output logic [W-1:0] q_data
);
    logic [W-1:0] mem [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_data  = mem[rptr_reg];
endmodule

/* sv/dbfw_front.sv */
// ----------------------------------------------------------------------------
// dbfw_front
// Accepts items, keeps buffer and flush-engine state, and queues at most one result
// descriptor per item (erase descriptors carry the clean-block merge mask).
// ----------------------------------------------------------------------------
module dbfw_front #(
    parameter int SECTOR_BYTES = 4096,
    parameter int BLOCK_BYTES  = 512,
    parameter int PAGE_BYTES   = 256,
    parameter int MW           = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [dbfw_pkg::BN_W-1:0]     s_block_number,
    input  logic [dbfw_pkg::LEN_W-1:0]    s_byte_offset,
    input  logic [dbfw_pkg::LEN_W-1:0]    s_byte_length,
    input  logic                          s_flash_busy,
    input  logic                          s_dma_done,
    input  logic                          cfg_valid,
    input  logic [dbfw_pkg::TOTAL_W-1:0]  cfg_data,
    input  logic                          q_full,
    output logic                          push,
    output dbfw_pkg::res_t                push_res,
    output logic [MW-1:0]                 push_mask
);
    import dbfw_pkg::*;

    localparam int SL   = $clog2(SECTOR_BYTES);
    localparam int BL   = $clog2(BLOCK_BYTES);
    localparam int PL   = $clog2(PAGE_BYTES);
    localparam int PPS  = SECTOR_BYTES / PAGE_BYTES;
    localparam int PCW  = $clog2(PPS);
    localparam int SW   = ADDR_W - SL;
    localparam int BIW  = SL - BL;
    localparam int AWW  = BN_W + BL + 1;
    localparam int CW   = 14;

    logic [TOTAL_W-1:0] total_reg;
    logic [SW-1:0]      held_reg [2], held_next [2];
    logic [1:0]         svalid_reg, svalid_next;
    logic [MW-1:0]      dirty_reg [2], dirty_next [2];
    bphase_t            bph_reg [2], bph_next [2];
    logic               active_reg, active_next;
    fphase_t            fph_reg, fph_next;
    logic               fbuf_reg, fbuf_next;
    logic [PCW-1:0]     page_reg, page_next;

    logic               acc;
    logic               range_bad;
    logic [AWW-1:0]     addr_wide;
    logic [ADDR_W-1:0]  addr;
    logic [SW-1:0]      sector;
    logic [SL-1:0]      osec;
    logic [BIW-1:0]     bidx;
    logic [MW-1:0]      blk_bit;
    logic [ADDR_W-1:0]  base;
    logic               a, nx, hit, hit0, hit1, fb;
    logic [MW-1:0]      full_mask;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign full_mask = '1;

    always_comb begin
        range_bad = ({1'b0, s_block_number} >= total_reg)
                 || (CW'(s_byte_offset) > CW'(BLOCK_BYTES))
                 || (CW'(s_byte_length) + CW'(s_byte_offset) > CW'(BLOCK_BYTES));
        addr_wide = (AWW'(s_block_number) << BL) + AWW'(s_byte_offset);
        addr      = addr_wide[ADDR_W-1:0];
        sector    = addr[ADDR_W-1:SL];
        osec      = addr[SL-1:0];
        bidx      = osec[SL-1:BL];
        blk_bit   = (32'(bidx) < MW) ? (MW'(1) << bidx) : '0;
    end

    always_comb begin
        held_next   = held_reg;
        svalid_next = svalid_reg;
        dirty_next  = dirty_reg;
        bph_next    = bph_reg;
        active_next = active_reg;
        fph_next    = fph_reg;
        fbuf_next   = fbuf_reg;
        page_next   = page_reg;
        push        = 1'b0;
        push_res    = '0;
        push_mask   = '0;
        a    = active_reg;
        nx   = ~active_reg;
        hit0 = 1'b0;
        hit1 = 1'b0;
        hit  = 1'b0;
        fb   = fbuf_reg;
        base = {held_reg[fbuf_reg], SL'(0)};

        if (acc) begin
            case (opcode_t'(s_opcode))
                OP_WRITE, OP_READ: begin
                    push = 1'b1;
                    if (range_bad) begin
                        push_res.kind = K_RANGE_ERR;
                    end else if (opcode_t'(s_opcode) == OP_READ) begin
                        hit0 = svalid_reg[0] && bph_reg[0] != BP_FREE
                               && held_reg[0] == sector;
                        hit1 = svalid_reg[1] && bph_reg[1] != BP_FREE
                               && held_reg[1] == sector;
                        hit  = !hit0;
                        push_res.cnt = s_byte_length;
                        if ((hit0 || hit1) && (dirty_reg[hit] & blk_bit) != '0) begin
                            push_res.kind = K_READ_BUF;
                            push_res.sel  = hit;
                            push_res.boff = BOFF_W'(osec);
                        end else begin
                            push_res.kind = K_READ_FL;
                            push_res.addr = addr;
                        end
                    end else begin
                        if (!(svalid_reg[a] && bph_reg[a] == BP_ACTIVE
                              && held_reg[a] == sector)) begin
                            if (bph_reg[a] == BP_ACTIVE && dirty_reg[a] != '0)
                                bph_next[a] = BP_PENDING;
                            if (bph_reg[nx] == BP_PENDING || bph_reg[nx] == BP_FLUSHING) begin
                                push_res.kind = K_RETRY;
                            end else begin
                                a               = nx;
                                active_next     = nx;
                                held_next[nx]   = sector;
                                svalid_next[nx] = 1'b1;
                                dirty_next[nx]  = '0;
                                bph_next[nx]    = BP_ACTIVE;
                            end
                        end
                        if (push_res.kind != K_RETRY) begin
                            if (s_byte_length != '0)
                                dirty_next[a] = dirty_next[a] | blk_bit;
                            push_res.kind = K_WRITE;
                            push_res.sel  = a;
                            push_res.boff = BOFF_W'(osec);
                            push_res.cnt  = s_byte_length;
                            if (dirty_next[a] == full_mask) begin
                                bph_next[a] = BP_PENDING;
                                active_next = ~a;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    case (fph_reg)
                        FL_ERASE_START: begin
                            if (dirty_reg[fb] != full_mask)
                                push_mask = ~dirty_reg[fb];
                            dirty_next[fb] = full_mask;
                            push          = 1'b1;
                            push_res.kind = K_ERASE;
                            push_res.addr = base;
                            push_res.sel  = fb;
                            fph_next      = FL_ERASE_WAIT;
                        end
                        FL_ERASE_WAIT: begin
                            if (!s_flash_busy) begin
                                page_next = '0;
                                fph_next  = FL_PAGE_START;
                            end
                        end
                        FL_PAGE_START: begin
                            push          = 1'b1;
                            push_res.kind = K_PROGRAM;
                            push_res.addr = base | (ADDR_W'(page_reg) << PL);
                            push_res.sel  = fb;
                            push_res.boff = BOFF_W'(32'(page_reg) << PL);
                            push_res.cnt  = CNT_W'(PAGE_BYTES);
                            fph_next      = FL_DMA_WAIT;
                        end
                        FL_DMA_WAIT: begin
                            if (s_dma_done) fph_next = FL_BUSY_WAIT;
                        end
                        FL_BUSY_WAIT: begin
                            if (!s_flash_busy) begin
                                if (page_reg != PCW'(PPS - 1)) begin
                                    page_next = page_reg + 1'b1;
                                    fph_next  = FL_PAGE_START;
                                end else begin
                                    dirty_next[fb] = '0;
                                    bph_next[fb]   = BP_FREE;
                                    push           = 1'b1;
                                    push_res.kind  = K_DONE;
                                    push_res.addr  = base;
                                    push_res.sel   = fb;
                                    fbuf_next      = 1'b0;
                                    page_next      = '0;
                                    fph_next       = FL_IDLE;
                                end
                            end
                        end
                        default: begin
                            fph_next = FL_IDLE;
                            if (bph_reg[0] == BP_PENDING) begin
                                fbuf_next   = 1'b0;
                                bph_next[0] = BP_FLUSHING;
                                fph_next    = FL_ERASE_START;
                            end else if (bph_reg[1] == BP_PENDING) begin
                                fbuf_next   = 1'b1;
                                bph_next[1] = BP_FLUSHING;
                                fph_next    = FL_ERASE_START;
                            end
                        end
                    endcase
                end
                default: begin
                    if (bph_reg[a] == BP_ACTIVE && dirty_reg[a] != '0)
                        bph_next[a] = BP_PENDING;
                    push = 1'b1;
                    if (fph_reg != FL_IDLE
                        || bph_next[0] == BP_PENDING || bph_next[0] == BP_FLUSHING
                        || bph_next[1] == BP_PENDING || bph_next[1] == BP_FLUSHING)
                        push_res.kind = K_SYNC_BUSY;
                    else
                        push_res.kind = K_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= TOTAL_W'(65536);
            held_reg   <= '{default: '0};
            svalid_reg <= '0;
            dirty_reg  <= '{default: '0};
            bph_reg    <= '{default: BP_FREE};
            active_reg <= 1'b0;
            fph_reg    <= FL_IDLE;
            fbuf_reg   <= 1'b0;
            page_reg   <= '0;
        end else begin
            if (cfg_valid) total_reg <= cfg_data;
            held_reg   <= held_next;
            svalid_reg <= svalid_next;
            dirty_reg  <= dirty_next;
            bph_reg    <= bph_next;
            active_reg <= active_next;
            fph_reg    <= fph_next;
            fbuf_reg   <= fbuf_next;
            page_reg   <= page_next;
        end
    end
endmodule

/* sv/dbfw_back.sv */
// ----------------------------------------------------------------------------
// dbfw_back
// Expands queued descriptors into result transfers: merge reads of clean
// blocks come first, then the descriptor itself marked last.
// ----------------------------------------------------------------------------
module dbfw_back #(
    parameter int BLOCK_BYTES = 512,
    parameter int MW          = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  dbfw_pkg::res_t               q_res,
    input  logic [MW-1:0]                q_mask,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_kind,
    output logic [dbfw_pkg::ADDR_W-1:0]  m_flash_address,
    output logic                         m_buffer_select,
    output logic [dbfw_pkg::BOFF_W-1:0]  m_buffer_offset,
    output logic [dbfw_pkg::CNT_W-1:0]   m_byte_count,
    output logic                         m_last
);
    import dbfw_pkg::*;

    localparam int BL  = $clog2(BLOCK_BYTES);
    localparam int IW  = (MW > 1) ? $clog2(MW) : 1;

    logic          cur_valid_reg;
    res_t          cur_reg;
    logic [MW-1:0] mask_reg;
    logic [2:0]    nm_reg;
    logic          m_valid_reg, m_last_reg;
    res_t          m_res_reg;
    logic          slot_free, do_merge;
    logic [IW-1:0] low_idx;

    assign slot_free = !m_valid_reg || m_ready;
    assign pop       = !cur_valid_reg && q_valid;
    assign do_merge  = mask_reg != '0 && nm_reg != 3'(MAX_MERGE);

    always_comb begin
        low_idx = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (mask_reg[i]) low_idx = IW'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (cur_valid_reg && slot_free) begin
            if (do_merge) begin
                m_res_reg.kind <= K_MERGE;
                m_res_reg.addr <= cur_reg.addr | (ADDR_W'(low_idx) << BL);
                m_res_reg.sel  <= cur_reg.sel;
                m_res_reg.boff <= BOFF_W'(32'(low_idx) << BL);
                m_res_reg.cnt  <= CNT_W'(BLOCK_BYTES);
                m_last_reg     <= 1'b0;
            end else begin
                m_res_reg  <= cur_reg;
                m_last_reg <= 1'b1;
            end
        end
        if (pop) begin
            cur_reg <= q_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            mask_reg      <= '0;
            nm_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
                mask_reg      <= q_mask;
                nm_reg        <= '0;
            end else if (cur_valid_reg && slot_free) begin
                if (do_merge) begin
                    mask_reg[low_idx] <= 1'b0;
                    nm_reg            <= nm_reg + 3'd1;
                end else begin
                    cur_valid_reg <= 1'b0;
                end
            end
            if (slot_free) m_valid_reg <= cur_valid_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_res_reg.kind;
    assign m_flash_address = m_res_reg.addr;
    assign m_buffer_select = m_res_reg.sel;
    assign m_buffer_offset = m_res_reg.boff;
    assign m_byte_count    = m_res_reg.cnt;
    assign m_last          = m_last_reg;
endmodule

/* sv/double_buffered_flash_sector_writeback_unit.sv */
// ----------------------------------------------------------------------------
// double_buffered_flash_sector_writeback_unit
// Metadata controller for two sector write-back buffers in front of NOR flash.
//
//   channel   dir  handshake           payload
//   s_*       in   s_valid/s_ready     opcode, block, offset, length, status
//   m_*       out  m_valid/m_ready     kind, address, buffer, offset, count, last
//   cfg_*     in   cfg_valid/cfg_ready block limit
//
// An item is classified and its state updated in the cycle it is taken; its
// result passes the queue and the back end's current and output registers.
// Erase ticks give up to eight transfers, one per cycle while m_ready holds,
// others one or none. The front takes items while the two-entry queue has
// room, so output stalls back up there. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module double_buffered_flash_sector_writeback_unit #(
    parameter int SECTOR_BYTES = 4096,
    parameter int BLOCK_BYTES  = 512,
    parameter int PAGE_BYTES   = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [dbfw_pkg::BN_W-1:0]     s_block_number,
    input  logic [dbfw_pkg::LEN_W-1:0]    s_byte_offset,
    input  logic [dbfw_pkg::LEN_W-1:0]    s_byte_length,
    input  logic                          s_flash_busy,
    input  logic                          s_dma_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dbfw_pkg::TOTAL_W-1:0]  cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_kind,
    output logic [dbfw_pkg::ADDR_W-1:0]   m_flash_address,
    output logic                          m_buffer_select,
    output logic [dbfw_pkg::BOFF_W-1:0]   m_buffer_offset,
    output logic [dbfw_pkg::CNT_W-1:0]    m_byte_count,
    output logic                          m_last
);
    import dbfw_pkg::*;

    localparam int BPS = SECTOR_BYTES / BLOCK_BYTES;
    localparam int MW  = (BPS >= 32) ? 32 : BPS;
    localparam int QW  = $bits(res_t) + MW;

    logic          push, q_full, pop, q_valid;
    res_t          push_res, q_res;
    logic [MW-1:0] push_mask, q_mask;
    logic [QW-1:0] q_data;

    assign cfg_ready = 1'b1;

    dbfw_front #(
        .SECTOR_BYTES(SECTOR_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .PAGE_BYTES  (PAGE_BYTES),
        .MW          (MW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_block_number(s_block_number),
        .s_byte_offset (s_byte_offset),
        .s_byte_length (s_byte_length),
        .s_flash_busy  (s_flash_busy),
        .s_dma_done    (s_dma_done),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .push          (push),
        .push_res      (push_res),
        .push_mask     (push_mask)
    );

    dbfw_queue #(.W(QW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data({push_mask, push_res}),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    assign q_res  = q_data[$bits(res_t)-1:0];
    assign q_mask = q_data[QW-1:$bits(res_t)];

    dbfw_back #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .MW         (MW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_res          (q_res),
        .q_mask         (q_mask),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_flash_address(m_flash_address),
        .m_buffer_select(m_buffer_select),
        .m_buffer_offset(m_buffer_offset),
        .m_byte_count   (m_byte_count),
        .m_last         (m_last)
    );
endmodule

/* sv/dbfw_checker.sv */
// ----------------------------------------------------------------------------
// dbfw_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dbfw_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_kind,
    input logic       m_last
);
    import dbfw_pkg::*;

    // a held transfer keeps its kind and last flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last))
        else $error("result changed while stalled");

    a_no_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind != K_NONE && m_kind <= K_SYNC_BUSY)
        else $error("bad result kind");

    // merge reads always precede the erase of the same tick
    a_merge_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == K_MERGE |-> !m_last)
        else $error("merge read flagged last");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != K_MERGE |-> m_last)
        else $error("single result not flagged last");

    a_merge_then: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == K_MERGE |=> !m_valid || m_kind == K_MERGE
            || m_kind == K_ERASE)
        else $error("merge read not followed by merge or erase");
endmodule

bind double_buffered_flash_sector_writeback_unit dbfw_checker u_dbfw_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_kind (m_kind),
    .m_last (m_last)
);

/* sim/double_buffered_flash_sector_writeback_unit_tb.sv */
// ----------------------------------------------------------------------------
// double_buffered_flash_sector_writeback_unit_tb
// Self-checking bench for the sector write-back controller. A clocked driver
// feeds queued commands, a behavioral predictor tracks buffer and flush state
// per accepted transfer, and a clocked monitor compares every result transfer
// against the oldest prediction. Random idling on both sides, one long output
// stall, and several block-count limits including the extremes.
// ----------------------------------------------------------------------------
module double_buffered_flash_sector_writeback_unit_tb;
    import dbfw_pkg::*;

    localparam int SEC_B      = 4096;
    localparam int BLK_B      = 512;
    localparam int PAGE_B     = 256;
    localparam int PAGES      = SEC_B / PAGE_B;
    localparam logic [7:0] ALL_DIRTY = 8'hFF;
    localparam logic [24:0] AMASK = 25'h1FFFFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        opcode_t     op;
        logic [15:0] bn;
        logic [9:0]  off;
        logic [9:0]  len;
        logic        fbusy;
        logic        ddone;
    } cmd_t;

    typedef struct {
        res_t r;
        logic last;
    } exp_t;

    logic aclk, aresetn;
    logic s_valid, s_ready;
    logic [1:0]  s_opcode;
    logic [15:0] s_block_number;
    logic [9:0]  s_byte_offset, s_byte_length;
    logic s_flash_busy, s_dma_done;
    logic cfg_valid, cfg_ready;
    logic [16:0] cfg_data;
    logic m_valid, m_ready;
    logic [3:0]  m_kind;
    logic [24:0] m_flash_address;
    logic m_buffer_select;
    logic [11:0] m_buffer_offset;
    logic [9:0]  m_byte_count;
    logic m_last;

    double_buffered_flash_sector_writeback_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_block_number(s_block_number), .s_byte_offset(s_byte_offset),
        .s_byte_length(s_byte_length), .s_flash_busy(s_flash_busy),
        .s_dma_done(s_dma_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_flash_address(m_flash_address), .m_buffer_select(m_buffer_select),
        .m_buffer_offset(m_buffer_offset), .m_byte_count(m_byte_count),
        .m_last(m_last)
    );

    // predictor state
    logic [16:0] blk_limit;
    logic [12:0] sec_tag [2];
    logic        sec_ok  [2];
    logic [7:0]  dirty   [2];
    bphase_t     bphase  [2];
    logic        act_buf;
    fphase_t     fphase;
    logic        flush_buf;
    int          page_idx;

    cmd_t pend_q[$];
    exp_t result_q[$];
    cmd_t cur_cmd;
    bit   failed, quiet, hold_req;
    int   cycles;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("double_buffered_flash_sector_writeback_unit_tb: errors");
            $finish;
        end
    end

    function automatic void push_result(kind_t k, logic [24:0] a, logic sel,
                                        logic [11:0] bo, logic [9:0] cnt);
        exp_t e;
        e.r.kind = k;
        e.r.addr = a;
        e.r.sel  = sel;
        e.r.boff = bo;
        e.r.cnt  = cnt;
        e.last   = 1'b0;
        result_q.push_back(e);
    endfunction

    function automatic bit is_busy(logic b);
        return bphase[b] == BP_PENDING || bphase[b] == BP_FLUSHING;
    endfunction

    function automatic void flush_step(logic fb_in, logic dd);
        logic fb;
        logic [24:0] base;
        fb = flush_buf;
        base = (25'(sec_tag[fb]) * SEC_B) & AMASK;
        case (fphase)
            FL_ERASE_START: begin
                if (dirty[fb] != ALL_DIRTY) begin
                    for (int b = 0; b < 8; b++)
                        if (!dirty[fb][b])
                            push_result(K_MERGE, 25'(base + b * BLK_B), fb,
                                        12'(b * BLK_B), 10'(BLK_B));
                    dirty[fb] = ALL_DIRTY;
                end
                push_result(K_ERASE, base, fb, 0, 0);
                fphase = FL_ERASE_WAIT;
            end
            FL_ERASE_WAIT: if (!fb_in) begin
                page_idx = 0;
                fphase = FL_PAGE_START;
            end
            FL_PAGE_START: begin
                push_result(K_PROGRAM, 25'(base + page_idx * PAGE_B), fb,
                            12'(page_idx * PAGE_B), 10'(PAGE_B));
                fphase = FL_DMA_WAIT;
            end
            FL_DMA_WAIT: if (dd) fphase = FL_BUSY_WAIT;
            FL_BUSY_WAIT: if (!fb_in) begin
                if (page_idx + 1 < PAGES) begin
                    page_idx++;
                    fphase = FL_PAGE_START;
                end else begin
                    dirty[fb] = 0;
                    bphase[fb] = BP_FREE;
                    push_result(K_DONE, base, fb, 0, 0);
                    flush_buf = 0;
                    page_idx = 0;
                    fphase = FL_IDLE;
                end
            end
            default: begin
                fphase = FL_IDLE;
                for (int b = 0; b < 2; b++)
                    if (bphase[b] == BP_PENDING) begin
                        flush_buf = b[0];
                        bphase[b] = BP_FLUSHING;
                        fphase = FL_ERASE_START;
                        break;
                    end
            end
        endcase
    endfunction

    function automatic void predict_cmd(cmd_t c);
        int n0;
        logic [31:0] addr32;
        logic [24:0] addr;
        logic [12:0] sector;
        logic [11:0] osec;
        int bidx, hit;
        logic a, nx;
        n0 = result_q.size();
        if (c.op == OP_WRITE || c.op == OP_READ) begin
            if (32'(c.bn) >= 32'(blk_limit) || c.off > BLK_B || 32'(c.len) > BLK_B - 32'(c.off)) begin
                push_result(K_RANGE_ERR, 0, 0, 0, 0);
            end else begin
                addr32 = 32'(c.bn) * BLK_B + 32'(c.off);
                addr = addr32[24:0];
                sector = addr[24:12];
                osec = addr[11:0];
                bidx = osec / BLK_B;
                if (c.op == OP_READ) begin
                    hit = -1;
                    for (int i = 0; i < 2; i++)
                        if (sec_ok[i] && bphase[i] != BP_FREE && sec_tag[i] == sector) begin
                            hit = i;
                            break;
                        end
                    if (hit >= 0 && dirty[hit][bidx])
                        push_result(K_READ_BUF, 0, hit[0], osec, c.len);
                    else
                        push_result(K_READ_FL, addr, 0, 0, c.len);
                end else begin
                    a = act_buf;
                    if (!(sec_ok[a] && bphase[a] == BP_ACTIVE && sec_tag[a] == sector)) begin
                        nx = ~a;
                        if (bphase[a] == BP_ACTIVE && dirty[a] != 0)
                            bphase[a] = BP_PENDING;
                        if (is_busy(nx)) begin
                            push_result(K_RETRY, 0, 0, 0, 0);
                            result_q[result_q.size()-1].last = 1'b1;
                            return;
                        end
                        a = nx;
                        act_buf = a;
                        sec_tag[a] = sector;
                        sec_ok[a] = 1;
                        dirty[a] = 0;
                        bphase[a] = BP_ACTIVE;
                    end
                    if (c.len > 0) dirty[a][bidx] = 1'b1;
                    push_result(K_WRITE, 0, a, osec, c.len);
                    if (dirty[a] == ALL_DIRTY) begin
                        bphase[a] = BP_PENDING;
                        act_buf = ~a;
                    end
                end
            end
        end else if (c.op == OP_TICK) begin
            flush_step(c.fbusy, c.ddone);
        end else begin
            a = act_buf;
            if (bphase[a] == BP_ACTIVE && dirty[a] != 0) bphase[a] = BP_PENDING;
            if (fphase != FL_IDLE || is_busy(0) || is_busy(1))
                push_result(K_SYNC_BUSY, 0, 0, 0, 0);
            else
                push_result(K_DONE, 0, 0, 0, 0);
        end
        if (result_q.size() > n0) result_q[result_q.size()-1].last = 1'b1;
    endfunction

    // driver
    int s_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) predict_cmd(cur_cmd);
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_cmd = pend_q.pop_front();
                    s_opcode       <= cur_cmd.op;
                    s_block_number <= cur_cmd.bn;
                    s_byte_offset  <= cur_cmd.off;
                    s_byte_length  <= cur_cmd.len;
                    s_flash_busy   <= cur_cmd.fbusy;
                    s_dma_done     <= cur_cmd.ddone;
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_gap, hold_left;
    bit hold_done;
    always @(posedge aclk) begin
        exp_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_gap = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result transfer: kind %0d", m_kind);
                    failed = 1;
                end else begin
                    e = result_q.pop_front();
                    if (m_kind !== e.r.kind) begin
                        $error("kind: expected %0d, got %0d", e.r.kind, m_kind);
                        failed = 1;
                    end
                    if (m_flash_address !== e.r.addr) begin
                        $error("flash_address: expected %h, got %h", e.r.addr, m_flash_address);
                        failed = 1;
                    end
                    if (m_buffer_select !== e.r.sel) begin
                        $error("buffer_select: expected %0d, got %0d", e.r.sel, m_buffer_select);
                        failed = 1;
                    end
                    if (m_buffer_offset !== e.r.boff) begin
                        $error("buffer_offset: expected %0d, got %0d", e.r.boff, m_buffer_offset);
                        failed = 1;
                    end
                    if (m_byte_count !== e.r.cnt) begin
                        $error("byte_count: expected %0d, got %0d", e.r.cnt, m_byte_count);
                        failed = 1;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_last);
                        failed = 1;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) m_gap = $urandom_range(1, 11);
            end
        end
    end

    function automatic cmd_t mk(opcode_t op, int bn, int off, int len, bit fb, bit dd);
        cmd_t c;
        c.op = op;
        c.bn = bn[15:0];
        c.off = off[9:0];
        c.len = len[9:0];
        c.fbusy = fb;
        c.ddone = dd;
        return c;
    endfunction

    // block numbers mostly from a few sectors so buffers hit and fill
    function automatic int pick_block();
        int secs [6] = '{0, 1, 2, 37, 8190, 8191};
        if ($urandom_range(0, 9) < 7)
            return secs[$urandom_range(0, 5)] * 8 + $urandom_range(0, 7);
        return $urandom_range(0, 65535);
    endfunction

    function automatic void pick_span(output int off, output int len);
        if ($urandom_range(0, 9) == 0) begin
            off = $urandom_range(0, 1023);
            len = $urandom_range(0, 1023);
        end else begin
            off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 512) : 0;
            len = $urandom_range(0, 512 - off);
        end
    endfunction

    task automatic gen_random(int count);
        int k, off, len, base, nt;
        k = 0;
        while (k < count) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    pick_span(off, len);
                    pend_q.push_back(mk(OP_WRITE, pick_block(), off, len,
                                        1'($urandom), 1'($urandom)));
                    k++;
                end
                6: begin
                    // whole-sector fill
                    base = pick_block() & 16'hFFF8;
                    for (int b = 0; b < 8; b++)
                        pend_q.push_back(mk(OP_WRITE, base + b, 0, $urandom_range(1, 512),
                                            1'($urandom), 1'($urandom)));
                    k += 8;
                end
                7, 8, 9, 10: begin
                    pick_span(off, len);
                    pend_q.push_back(mk(OP_READ, pick_block(), off, len,
                                        1'($urandom), 1'($urandom)));
                    k++;
                end
                11: begin
                    pend_q.push_back(mk(OP_SYNC, $urandom, $urandom, $urandom,
                                        1'($urandom), 1'($urandom)));
                    k++;
                end
                default: begin
                    nt = $urandom_range(1, 12);
                    for (int t = 0; t < nt; t++)
                        pend_q.push_back(mk(OP_TICK, $urandom, $urandom, $urandom,
                                            $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0));
                    k += nt;
                end
            endcase
        end
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_limit(logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        blk_limit = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn = 0; cfg_valid = 0; cfg_data = 0;
        s_opcode = 0; s_block_number = 0; s_byte_offset = 0; s_byte_length = 0;
        s_flash_busy = 0; s_dma_done = 0;
        failed = 0; quiet = 0; hold_req = 0; hold_done = 0; cycles = 0;
        blk_limit = 17'd65536;
        for (int i = 0; i < 2; i++) begin
            sec_tag[i] = 0; sec_ok[i] = 0; dirty[i] = 0; bphase[i] = BP_FREE;
        end
        act_buf = 0; fphase = FL_IDLE; flush_buf = 0; page_idx = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, range errors, zero length, hits, flush walk
        pend_q.push_back(mk(OP_READ, 0, 0, 512, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 65535, 0, 512, 1, 1));
        pend_q.push_back(mk(OP_WRITE, 65535, 512, 0, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 0, 513, 0, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 0, 100, 413, 0, 0));
        pend_q.push_back(mk(OP_READ, 65535, 1023, 1023, 1, 1));
        pend_q.push_back(mk(OP_WRITE, 8, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 9, 5, 10, 0, 0));
        pend_q.push_back(mk(OP_READ, 9, 0, 1, 0, 0));
        pend_q.push_back(mk(OP_READ, 10, 0, 1, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 24, 0, 1, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 32, 0, 1, 0, 0));
        pend_q.push_back(mk(OP_SYNC, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 1));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
        for (int p = 0; p < 16; p++) pend_q.push_back(mk(OP_TICK, 0, 0, 0, 0, 1));
        pend_q.push_back(mk(OP_SYNC, 0, 0, 0, 0, 0));
        drain();

        write_limit(17'd1);
        gen_random(40);
        drain();

        write_limit(17'd131071);
        hold_req = 1;
        gen_random(110);
        drain();

        write_limit(17'd0);
        gen_random(20);
        drain();

        write_limit(17'd300);
        gen_random(90);
        drain();

        write_limit(17'd65536);
        gen_random(60);
        while (pend_q.size() > 30) @(posedge aclk);
        quiet = 1;
        while (pend_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (!failed)
            $display("double_buffered_flash_sector_writeback_unit_tb: clean");
        else
            $display("double_buffered_flash_sector_writeback_unit_tb: errors");
        $finish;
    end

endmodule
